// File: design/bezier_edge_control_points_defines.svh
// Assertion helpers for the bezier edge control point block.
`ifndef BEZIER_EDGE_CONTROL_POINTS_DEFINES_SVH
`define BEZIER_EDGE_CONTROL_POINTS_DEFINES_SVH

// same-cycle implication
`define BECP_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define BECP_ASSERT_NXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/becp_pkg.sv
`default_nettype none

package becp_pkg;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MODE_WIDTH     = 4;
   localparam int ROUND_WIDTH    = 17;
   localparam int FRAC_BITS      = 16;

   localparam logic [ROUND_WIDTH-1:0] ONE_Q16     = 17'h10000;
   localparam logic [ROUND_WIDTH-1:0] ROUND_RESET = 17'h08000;
   localparam logic [MODE_WIDTH-1:0]  MODE_RESET  = 4'd0;

   // register index, taken from paddr[2]
   localparam logic REG_CURVE_MODE = 1'b0;
   localparam logic REG_ROUNDNESS  = 1'b1;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_Q_CONT     = 4'd0,
      MODE_Q_DISC     = 4'd1,
      MODE_Q_DIAG     = 4'd2,
      MODE_Q_STRAIGHT = 4'd3,
      MODE_Q_HORIZ    = 4'd4,
      MODE_Q_VERT     = 4'd5,
      MODE_C_CONT     = 4'd6,
      MODE_C_VERT     = 4'd7,
      MODE_C_DIAG     = 4'd8,
      MODE_C_VDIAG    = 4'd9,
      MODE_C_SSRC     = 4'd10,
      MODE_C_STGT     = 4'd11
   } curve_mode_type;

   typedef struct packed {
      logic sx_lt_tx;
      logic sx_gt_tx;
      logic sy_lt_ty;
      logic sy_gt_ty;
      logic dx_lt_dy;
      logic dx_gt_dy;
   } becp_flags_type;

endpackage

`default_nettype wire

// File: design/becp_ifs.sv
`default_nettype none

interface becp_req_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] src_x;
   logic signed [COORD_WIDTH-1:0] src_y;
   logic signed [COORD_WIDTH-1:0] src_z;
   logic signed [COORD_WIDTH-1:0] tgt_x;
   logic signed [COORD_WIDTH-1:0] tgt_y;
   logic signed [COORD_WIDTH-1:0] tgt_z;

   modport source (output valid, src_x, src_y, src_z, tgt_x, tgt_y, tgt_z, input ready);
   modport sink   (input valid, src_x, src_y, src_z, tgt_x, tgt_y, tgt_z, output ready);
endinterface

interface becp_rsp_if #(parameter int COORD_WIDTH = 32);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ctrl_x;
   logic signed [COORD_WIDTH-1:0] ctrl_y;
   logic signed [COORD_WIDTH-1:0] ctrl_z;
   logic                          point_index;
   logic                          last_point;

   modport source (output valid, ctrl_x, ctrl_y, ctrl_z, point_index, last_point, input ready);
   modport sink   (input valid, ctrl_x, ctrl_y, ctrl_z, point_index, last_point, output ready);
endinterface

`default_nettype wire

// File: design/bezier_edge_control_points.sv
// Bezier control points for one edge per request word. Modes 0-5 (quadratic)
// return one word, modes 6-11 (cubic) return two words, first point then
// second; modes 12-15 act as cubic continuous. Words leave a five-deep
// pipeline (difference, operand select, partial products, product sum,
// point assembly) into a two-point output register. Throughput: one edge
// per cycle in quadratic modes while rsp is not stalled; a cubic edge holds
// the output register until both its words are taken, since the single
// response channel carries both points. Stalls on rsp back up the stages
// without loss. Coordinates are signed Q16.16, results saturate to
// COORD_WIDTH bits. curve_mode sits at byte 0, roundness at byte 4; change
// them only while the block is drained.
`default_nettype none
`include "bezier_edge_control_points_defines.svh"

module bezier_edge_control_points #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   becp_req_if.sink                                 req_port,
   becp_rsp_if.source                               rsp_port,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [becp_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [becp_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [becp_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                     pready
);
   import becp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int SW = W + 4;
   localparam int HW = (W > FRAC_BITS) ? W - FRAC_BITS : 1;
   localparam int PW = HW + ROUND_WIDTH;

   function automatic logic signed [W-1:0] sat_coord(input logic signed [SW-1:0] v);
      logic [SW-W:0] top;
      top = v[SW-1:W-1];
      if (top == '0 || top == '1) begin
         return v[W-1:0];
      end else if (v[SW-1]) begin
         return {1'b1, {(W-1){1'b0}}};
      end else begin
         return {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   // ---------------- configuration ----------------
   logic [MODE_WIDTH-1:0]  curve_mode_ff;
   logic [ROUND_WIDTH-1:0] roundness_ff;
   logic                   csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_mode_ff <= MODE_RESET;
         roundness_ff  <= ROUND_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_CURVE_MODE: curve_mode_ff <= pwdata[MODE_WIDTH-1:0];
            REG_ROUNDNESS:  roundness_ff  <= pwdata[ROUND_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CURVE_MODE: prdata = CSR_DATA_WIDTH'(curve_mode_ff);
         REG_ROUNDNESS:  prdata = CSR_DATA_WIDTH'(roundness_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------- handshake chain ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic out_full_ff, out_sel_ff, out_cubic_ff;
   logic out_last, rdy_out, rdy4, rdy3, rdy2, rdy1;

   assign out_last = !out_cubic_ff || out_sel_ff;
   assign rdy_out  = !out_full_ff || (rsp_port.ready && out_last);
   assign rdy4     = !v4_ff || rdy_out;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign req_port.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_port.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: differences and magnitudes ----------------
   logic signed [DW-1:0] dxs_in, dys_in, dzs_in, nx_in, ny_in, nz_in;
   logic [W-1:0]         dx_in, dy_in, dz_in;
   curve_mode_type       mode_in;
   logic [ROUND_WIDTH-1:0] r_in;

   logic signed [W-1:0]  s1_sx_ff, s1_sy_ff, s1_sz_ff, s1_tx_ff, s1_ty_ff, s1_tz_ff;
   logic signed [DW-1:0] s1_dxs_ff, s1_dys_ff, s1_dzs_ff;
   logic [W-1:0]         s1_dx_ff, s1_dy_ff, s1_dz_ff;
   curve_mode_type       s1_mode_ff;
   logic [ROUND_WIDTH-1:0] s1_r_ff;

   always_comb begin
      dxs_in = {req_port.tgt_x[W-1], req_port.tgt_x} - {req_port.src_x[W-1], req_port.src_x};
      dys_in = {req_port.tgt_y[W-1], req_port.tgt_y} - {req_port.src_y[W-1], req_port.src_y};
      dzs_in = {req_port.tgt_z[W-1], req_port.tgt_z} - {req_port.src_z[W-1], req_port.src_z};
      nx_in  = -dxs_in;
      ny_in  = -dys_in;
      nz_in  = -dzs_in;
      dx_in  = dxs_in[DW-1] ? nx_in[W-1:0] : dxs_in[W-1:0];
      dy_in  = dys_in[DW-1] ? ny_in[W-1:0] : dys_in[W-1:0];
      dz_in  = dzs_in[DW-1] ? nz_in[W-1:0] : dzs_in[W-1:0];
      mode_in = (curve_mode_ff > MODE_C_STGT) ? MODE_C_CONT : curve_mode_type'(curve_mode_ff);
      r_in    = (roundness_ff > ONE_Q16) ? ONE_Q16 : roundness_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_port.valid) begin
         s1_sx_ff   <= req_port.src_x;
         s1_sy_ff   <= req_port.src_y;
         s1_sz_ff   <= req_port.src_z;
         s1_tx_ff   <= req_port.tgt_x;
         s1_ty_ff   <= req_port.tgt_y;
         s1_tz_ff   <= req_port.tgt_z;
         s1_dxs_ff  <= dxs_in;
         s1_dys_ff  <= dys_in;
         s1_dzs_ff  <= dzs_in;
         s1_dx_ff   <= dx_in;
         s1_dy_ff   <= dy_in;
         s1_dz_ff   <= dz_in;
         s1_mode_ff <= mode_in;
         s1_r_ff    <= r_in;
      end
   end

   // ---------------- stage 2: compares and multiplier operands ----------------
   becp_flags_type         flags_in;
   logic [W-1:0]           mag_x_in;
   logic                   neg_x_in;
   logic [ROUND_WIDTH-1:0] fac_x_in, inv_r;

   logic signed [W-1:0]    s2_sx_ff, s2_sy_ff, s2_sz_ff, s2_tx_ff, s2_ty_ff, s2_tz_ff;
   logic [W-1:0]           s2_dx_ff, s2_dy_ff;
   becp_flags_type         s2_flags_ff;
   curve_mode_type         s2_mode_ff;
   logic [W-1:0]           s2_mag_x_ff, s2_mag_y_ff, s2_mag_z_ff;
   logic                   s2_neg_x_ff, s2_neg_y_ff, s2_neg_z_ff;
   logic [ROUND_WIDTH-1:0] s2_fac_x_ff, s2_r_ff;

   always_comb begin
      flags_in.sx_lt_tx = !s1_dxs_ff[DW-1] && (s1_dxs_ff != '0);
      flags_in.sx_gt_tx = s1_dxs_ff[DW-1];
      flags_in.sy_lt_ty = !s1_dys_ff[DW-1] && (s1_dys_ff != '0);
      flags_in.sy_gt_ty = s1_dys_ff[DW-1];
      flags_in.dx_lt_dy = s1_dx_ff < s1_dy_ff;
      flags_in.dx_gt_dy = s1_dx_ff > s1_dy_ff;
      inv_r    = ONE_Q16 - s1_r_ff;
      mag_x_in = s1_dx_ff;
      neg_x_in = 1'b0;
      fac_x_in = inv_r;
      unique case (s1_mode_ff) inside
         MODE_Q_CONT, MODE_Q_DISC, MODE_Q_DIAG: begin
            mag_x_in = flags_in.dx_gt_dy ? s1_dx_ff : s1_dy_ff;
            fac_x_in = s1_r_ff;
         end
         MODE_Q_STRAIGHT: begin
            mag_x_in = flags_in.dx_lt_dy ? s1_dy_ff : s1_dx_ff;
         end
         MODE_Q_HORIZ: begin
            mag_x_in = s1_dx_ff;
         end
         MODE_Q_VERT: begin
            mag_x_in = s1_dy_ff;
         end
         default: begin
            // cubic: signed x difference times roundness
            mag_x_in = s1_dx_ff;
            neg_x_in = s1_dxs_ff[DW-1];
            fac_x_in = s1_r_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         s2_sx_ff    <= s1_sx_ff;
         s2_sy_ff    <= s1_sy_ff;
         s2_sz_ff    <= s1_sz_ff;
         s2_tx_ff    <= s1_tx_ff;
         s2_ty_ff    <= s1_ty_ff;
         s2_tz_ff    <= s1_tz_ff;
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
         s2_flags_ff <= flags_in;
         s2_mode_ff  <= s1_mode_ff;
         s2_mag_x_ff <= mag_x_in;
         s2_mag_y_ff <= s1_dy_ff;
         s2_mag_z_ff <= s1_dz_ff;
         s2_neg_x_ff <= neg_x_in;
         s2_neg_y_ff <= s1_dys_ff[DW-1];
         s2_neg_z_ff <= s1_dzs_ff[DW-1];
         s2_fac_x_ff <= fac_x_in;
         s2_r_ff     <= s1_r_ff;
      end
   end

   // ---------------- stage 3: partial products ----------------
   // |a| * r / 2^16 = (|a| >> 16) * r + floor((|a| & 0xffff) * r / 2^16)
   logic [HW-1:0]            hop_x, hop_y, hop_z;
   logic [PW-1:0]            hi_x_in, hi_y_in, hi_z_in;
   logic [2*ROUND_WIDTH-2:0] lo_x_full, lo_y_full, lo_z_full;

   logic signed [W-1:0]    s3_sx_ff, s3_sy_ff, s3_sz_ff, s3_tx_ff, s3_ty_ff, s3_tz_ff;
   logic [W-1:0]           s3_dx_ff, s3_dy_ff;
   becp_flags_type         s3_flags_ff;
   curve_mode_type         s3_mode_ff;
   logic [PW-1:0]          s3_hi_x_ff, s3_hi_y_ff, s3_hi_z_ff;
   logic [ROUND_WIDTH-1:0] s3_lo_x_ff, s3_lo_y_ff, s3_lo_z_ff;
   logic                   s3_neg_x_ff, s3_neg_y_ff, s3_neg_z_ff;

   always_comb begin
      hop_x     = HW'(s2_mag_x_ff >> FRAC_BITS);
      hop_y     = HW'(s2_mag_y_ff >> FRAC_BITS);
      hop_z     = HW'(s2_mag_z_ff >> FRAC_BITS);
      hi_x_in   = PW'(hop_x) * PW'(s2_fac_x_ff);
      hi_y_in   = PW'(hop_y) * PW'(s2_r_ff);
      hi_z_in   = PW'(hop_z) * PW'(s2_r_ff);
      lo_x_full = (2*ROUND_WIDTH-1)'(s2_mag_x_ff[FRAC_BITS-1:0]) * (2*ROUND_WIDTH-1)'(s2_fac_x_ff);
      lo_y_full = (2*ROUND_WIDTH-1)'(s2_mag_y_ff[FRAC_BITS-1:0]) * (2*ROUND_WIDTH-1)'(s2_r_ff);
      lo_z_full = (2*ROUND_WIDTH-1)'(s2_mag_z_ff[FRAC_BITS-1:0]) * (2*ROUND_WIDTH-1)'(s2_r_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         s3_sx_ff    <= s2_sx_ff;
         s3_sy_ff    <= s2_sy_ff;
         s3_sz_ff    <= s2_sz_ff;
         s3_tx_ff    <= s2_tx_ff;
         s3_ty_ff    <= s2_ty_ff;
         s3_tz_ff    <= s2_tz_ff;
         s3_dx_ff    <= s2_dx_ff;
         s3_dy_ff    <= s2_dy_ff;
         s3_flags_ff <= s2_flags_ff;
         s3_mode_ff  <= s2_mode_ff;
         s3_hi_x_ff  <= hi_x_in;
         s3_hi_y_ff  <= hi_y_in;
         s3_hi_z_ff  <= hi_z_in;
         s3_lo_x_ff  <= lo_x_full[2*ROUND_WIDTH-2:FRAC_BITS];
         s3_lo_y_ff  <= lo_y_full[2*ROUND_WIDTH-2:FRAC_BITS];
         s3_lo_z_ff  <= lo_z_full[2*ROUND_WIDTH-2:FRAC_BITS];
         s3_neg_x_ff <= s2_neg_x_ff;
         s3_neg_y_ff <= s2_neg_y_ff;
         s3_neg_z_ff <= s2_neg_z_ff;
      end
   end

   // ---------------- stage 4: product sum and sign ----------------
   logic [DW-1:0]        psum_x, psum_y, psum_z;
   logic signed [DW-1:0] k_x_in, k_y_in, k_z_in;

   logic signed [W-1:0]  s4_sx_ff, s4_sy_ff, s4_sz_ff, s4_tx_ff, s4_ty_ff, s4_tz_ff;
   logic [W-1:0]         s4_dx_ff, s4_dy_ff;
   becp_flags_type       s4_flags_ff;
   curve_mode_type       s4_mode_ff;
   logic signed [DW-1:0] s4_kx_ff, s4_ky_ff, s4_kz_ff;

   always_comb begin
      psum_x = DW'(s3_hi_x_ff) + DW'(s3_lo_x_ff);
      psum_y = DW'(s3_hi_y_ff) + DW'(s3_lo_y_ff);
      psum_z = DW'(s3_hi_z_ff) + DW'(s3_lo_z_ff);
      k_x_in = s3_neg_x_ff ? -signed'(psum_x) : signed'(psum_x);
      k_y_in = s3_neg_y_ff ? -signed'(psum_y) : signed'(psum_y);
      k_z_in = s3_neg_z_ff ? -signed'(psum_z) : signed'(psum_z);
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         s4_sx_ff    <= s3_sx_ff;
         s4_sy_ff    <= s3_sy_ff;
         s4_sz_ff    <= s3_sz_ff;
         s4_tx_ff    <= s3_tx_ff;
         s4_ty_ff    <= s3_ty_ff;
         s4_tz_ff    <= s3_tz_ff;
         s4_dx_ff    <= s3_dx_ff;
         s4_dy_ff    <= s3_dy_ff;
         s4_flags_ff <= s3_flags_ff;
         s4_mode_ff  <= s3_mode_ff;
         s4_kx_ff    <= k_x_in;
         s4_ky_ff    <= k_y_in;
         s4_kz_ff    <= k_z_in;
      end
   end

   // ---------------- stage 5: point assembly ----------------
   logic signed [SW-1:0] e_sx, e_sy, e_sz, e_tx, e_ty, e_tz, e_ax, e_ay, e_az;
   logic signed [SW-1:0] x_near, y_near, x_far, y_far, q_x, q_y;
   logic signed [SW-1:0] p1x, p1y, p1z, p2x, p2y, p2z;
   logic signed [SW-1:0] c1_a, c1_n, c2_a, c2_n;
   logic [DW-1:0]        msum_x, msum_y, msum_z;
   logic                 q_ok, cubic, zero1, zero2, add_n1, sub_n2, add_n2;
   logic [W-1:0]         k_mag;

   logic signed [W-1:0]  p1x_in, p1y_in, p1z_in, p2x_in, p2y_in, p2z_in;

   always_comb begin
      e_sx = SW'(s4_sx_ff);
      e_sy = SW'(s4_sy_ff);
      e_sz = SW'(s4_sz_ff);
      e_tx = SW'(s4_tx_ff);
      e_ty = SW'(s4_ty_ff);
      e_tz = SW'(s4_tz_ff);
      e_ax = SW'(s4_kx_ff);
      e_ay = SW'(s4_ky_ff);
      e_az = SW'(s4_kz_ff);
      k_mag = s4_kx_ff[W-1:0];

      // quadratic candidates, k is non-negative here
      x_near = s4_flags_ff.sx_lt_tx ? e_sx + e_ax : e_sx - e_ax;
      y_near = s4_flags_ff.sy_lt_ty ? e_sy + e_ax : e_sy - e_ax;
      x_far  = s4_flags_ff.sx_lt_tx ? e_tx - e_ax : e_tx + e_ax;
      y_far  = s4_flags_ff.sy_lt_ty ? e_ty - e_ax : e_ty + e_ax;

      q_x  = e_sx;
      q_y  = e_sy;
      q_ok = 1'b1;
      unique case (s4_mode_ff) inside
         MODE_Q_CONT, MODE_Q_DISC, MODE_Q_DIAG: begin
            q_ok = (s4_flags_ff.dx_lt_dy || s4_flags_ff.dx_gt_dy)
                && (s4_flags_ff.sx_lt_tx || s4_flags_ff.sx_gt_tx)
                && (s4_flags_ff.sy_lt_ty || s4_flags_ff.sy_gt_ty);
            q_x = x_near;
            q_y = y_near;
            if (s4_mode_ff == MODE_Q_CONT) begin
               // clamp so the point does not pass the target
               if (s4_flags_ff.dx_lt_dy) begin
                  if ((s4_flags_ff.sx_lt_tx && e_tx < x_near) ||
                      (s4_flags_ff.sx_gt_tx && e_tx > x_near)) q_x = e_tx;
               end else begin
                  if ((s4_flags_ff.sy_gt_ty && e_ty > y_near) ||
                      (s4_flags_ff.sy_lt_ty && e_ty < y_near)) q_y = e_ty;
               end
            end else if (s4_mode_ff == MODE_Q_DISC) begin
               if (s4_flags_ff.dx_lt_dy && s4_dx_ff < k_mag) q_x = e_sx;
               if (s4_flags_ff.dx_gt_dy && s4_dy_ff < k_mag) q_y = e_sy;
            end
         end
         MODE_Q_STRAIGHT: begin
            if (s4_flags_ff.dx_lt_dy) begin
               q_x = e_sx;
               q_y = y_far;
            end else if (s4_flags_ff.dx_gt_dy) begin
               q_x = x_far;
               q_y = e_sy;
            end else begin
               q_ok = 1'b0;
            end
         end
         MODE_Q_HORIZ: begin
            q_x = x_far;
            q_y = e_sy;
         end
         MODE_Q_VERT: begin
            q_x = e_sx;
            q_y = y_far;
         end
         default: q_ok = 1'b0;
      endcase

      // midpoint, floor via arithmetic shift of the sum
      msum_x = {s4_sx_ff[W-1], s4_sx_ff} + {s4_tx_ff[W-1], s4_tx_ff};
      msum_y = {s4_sy_ff[W-1], s4_sy_ff} + {s4_ty_ff[W-1], s4_ty_ff};
      msum_z = {s4_sz_ff[W-1], s4_sz_ff} + {s4_tz_ff[W-1], s4_tz_ff};

      // cubic: n = (ay, -ax)
      cubic  = s4_mode_ff >= MODE_C_CONT;
      zero1  = s4_mode_ff == MODE_C_VERT || s4_mode_ff == MODE_C_VDIAG
            || s4_mode_ff == MODE_C_SSRC;
      zero2  = zero1 || s4_mode_ff == MODE_C_STGT;
      add_n1 = s4_mode_ff != MODE_C_STGT;
      sub_n2 = s4_mode_ff == MODE_C_DIAG || s4_mode_ff == MODE_C_VDIAG;
      add_n2 = !sub_n2 && s4_mode_ff != MODE_C_SSRC;

      c1_a = zero1 ? '0 : e_ax;
      c1_n = add_n1 ? e_ay : '0;
      p1x  = e_sx + c1_a + c1_n;
      c1_a = zero1 ? '0 : e_ay;
      c1_n = add_n1 ? e_ax : '0;
      p1y  = e_sy + c1_a - c1_n;
      p1z  = e_sz + (zero1 ? '0 : e_az);

      c2_a = zero2 ? '0 : e_ax;
      c2_n = sub_n2 ? -e_ay : (add_n2 ? e_ay : '0);
      p2x  = e_tx - c2_a + c2_n;
      c2_a = zero2 ? '0 : e_ay;
      c2_n = sub_n2 ? e_ax : (add_n2 ? -e_ax : '0);
      p2y  = e_ty - c2_a + c2_n;
      p2z  = e_tz - (zero2 ? '0 : e_az);

      if (cubic) begin
         p1x_in = sat_coord(p1x);
         p1y_in = sat_coord(p1y);
         p1z_in = sat_coord(p1z);
      end else if (q_ok) begin
         p1x_in = sat_coord(q_x);
         p1y_in = sat_coord(q_y);
         p1z_in = '0;
      end else begin
         p1x_in = msum_x[W:1];
         p1y_in = msum_y[W:1];
         p1z_in = msum_z[W:1];
      end
      p2x_in = sat_coord(p2x);
      p2y_in = sat_coord(p2y);
      p2z_in = sat_coord(p2z);
   end

   // ---------------- output register, two points ----------------
   logic signed [W-1:0] out_p1x_ff, out_p1y_ff, out_p1z_ff;
   logic signed [W-1:0] out_p2x_ff, out_p2y_ff, out_p2z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
         out_sel_ff  <= 1'b0;
      end else if (rdy_out) begin
         out_full_ff <= v4_ff;
         out_sel_ff  <= 1'b0;
      end else if (rsp_port.ready) begin
         // first cubic word taken, second one next
         out_sel_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out && v4_ff) begin
         out_cubic_ff <= cubic;
         out_p1x_ff   <= p1x_in;
         out_p1y_ff   <= p1y_in;
         out_p1z_ff   <= p1z_in;
         out_p2x_ff   <= p2x_in;
         out_p2y_ff   <= p2y_in;
         out_p2z_ff   <= p2z_in;
      end
   end

   assign rsp_port.valid       = out_full_ff;
   assign rsp_port.point_index = out_sel_ff;
   assign rsp_port.last_point  = out_last;
   assign rsp_port.ctrl_x      = out_sel_ff ? out_p2x_ff : out_p1x_ff;
   assign rsp_port.ctrl_y      = out_sel_ff ? out_p2y_ff : out_p1y_ff;
   assign rsp_port.ctrl_z      = out_sel_ff ? out_p2z_ff : out_p1z_ff;

   // ---------------- checks ----------------
   `BECP_ASSERT_NXT(a_second_follows, clock, reset,
      rsp_port.valid && rsp_port.ready && !rsp_port.last_point,
      rsp_port.valid && rsp_port.point_index, "second cubic point missing")
   `BECP_ASSERT_IMP(a_index_last, clock, reset,
      rsp_port.valid && rsp_port.point_index, rsp_port.last_point,
      "second point not marked last")
   `BECP_ASSERT_IMP(a_stall_full, clock, reset,
      !req_port.ready, v1_ff && v2_ff && v3_ff && v4_ff && out_full_ff,
      "request stalled with a free stage")
   `BECP_ASSERT_IMP(a_quad_single, clock, reset,
      out_full_ff && !out_cubic_ff, rsp_port.last_point && !rsp_port.point_index,
      "quadratic edge gave more than one word")

endmodule

`default_nettype wire
